### rtl/core/mma_pkg.sv
package mma_pkg;

  localparam int AccumWidth  = 12;
  localparam int ReportWidth = 7;
  localparam int TotalWidth  = 13;
  localparam int SumWidth    = TotalWidth + 1;

  localparam logic [AccumWidth-1:0]  AccumLimitReset  = 12'd2048;
  localparam logic [ReportWidth-1:0] ReportLimitReset = 7'd127;
  localparam logic [7:0]             ButtonsReset     = 8'h87;
  localparam logic [7:0]             HeadMarker       = 8'h80;
  localparam logic [2:0]             ReadMinLength    = 3'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_SAMPLE_TAKEN = 3'd0,
    ST_PACKET_GIVEN = 3'd1,
    ST_NO_DATA      = 3'd2,
    ST_READ_SHORT   = 3'd3,
    ST_CLEARED      = 3'd4
  } status_t;

  typedef enum logic {
    CFG_ACCUM_LIMIT  = 1'b0,
    CFG_REPORT_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] x_low;
    logic [3:0] x_high;
    logic [3:0] y_low;
    logic [7:0] y_high_buttons;
    logic [7:0] read_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        packet_head;
    logic signed [7:0] packet_dx;
    logic signed [7:0] packet_dy;
    logic              data_ready;
  } out_item_t;

  // Symmetric saturation of a widened running total to the accumulation bound.
  function automatic logic signed [TotalWidth-1:0] clamp_accum(
    input logic signed [SumWidth-1:0] v,
    input logic [AccumWidth-1:0]      lim
  );
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    logic signed [SumWidth-1:0] r;
    hi = $signed({{(SumWidth-AccumWidth){1'b0}}, lim});
    lo = -hi;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[TotalWidth-1:0];
  endfunction

  // Clamp a total to the largest delta one packet may carry.
  function automatic logic signed [7:0] clamp_report(
    input logic signed [TotalWidth-1:0] v,
    input logic [ReportWidth-1:0]       lim
  );
    logic signed [TotalWidth-1:0] hi;
    logic signed [TotalWidth-1:0] lo;
    logic signed [TotalWidth-1:0] r;
    hi = $signed({{(TotalWidth-ReportWidth){1'b0}}, lim});
    lo = -hi;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r[7:0];
  endfunction

endpackage

### rtl/core/mouse_motion_accumulator.sv
// Bus mouse motion accumulator. Each request is a hardware sample, a host read or a clear,
// and each produces exactly one result. Requests are taken one per cycle while the skid
// stage is empty: the state update and the result are worked out in the cycle a request
// is accepted, and the result sits in an output register backed by a one-entry skid stage,
// so a stalled result does not hold up the input until both are full. The two limit
// registers should only be written while no requests are in flight.
module mouse_motion_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mma_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mma_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mma_pkg::AccumWidth-1:0] cfg_data
);
  import mma_pkg::*;

  logic [AccumWidth-1:0]         accum_limit_r;
  logic [ReportWidth-1:0]        report_limit_r;
  logic [7:0]                    last_buttons_r, last_buttons_nxt;
  logic signed [TotalWidth-1:0]  total_x_r, total_x_nxt;
  logic signed [TotalWidth-1:0]  total_y_r, total_y_nxt;
  logic                          pending_r, pending_nxt;

  out_item_t                     out_r, skid_r, result;
  logic                          out_valid_r, skid_valid_r;
  logic                          in_accept, out_free;

  logic signed [7:0]             dx, dy;
  logic [2:0]                    btn;
  logic signed [SumWidth-1:0]    sum_x, sum_y;
  logic signed [7:0]             rx, ry;
  kind_t                         kind;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign kind  = kind_t'(in_data.kind);
  assign dx    = $signed({in_data.x_high, in_data.x_low});
  assign dy    = $signed({in_data.y_high_buttons[3:0], in_data.y_low});
  assign btn   = in_data.y_high_buttons[7:5];
  // Screen Y grows downwards, so the sample's Y delta is subtracted.
  assign sum_x = {total_x_r[TotalWidth-1], total_x_r}
               + {{(SumWidth-8){dx[7]}}, dx};
  assign sum_y = {total_y_r[TotalWidth-1], total_y_r}
               - {{(SumWidth-8){dy[7]}}, dy};
  assign rx    = clamp_report(total_x_r, report_limit_r);
  assign ry    = clamp_report(total_y_r, report_limit_r);

  always_comb begin
    last_buttons_nxt   = last_buttons_r;
    total_x_nxt        = total_x_r;
    total_y_nxt        = total_y_r;
    pending_nxt        = pending_r;
    result.status      = ST_NO_DATA;
    result.packet_head = '0;
    result.packet_dx   = '0;
    result.packet_dy   = '0;
    unique case (kind)
      KIND_SAMPLE: begin
        if (dx != 8'sd0 || dy != 8'sd0 || {5'b0, btn} != last_buttons_r) begin
          last_buttons_nxt = {5'b0, btn};
          total_x_nxt      = clamp_accum(sum_x, accum_limit_r);
          total_y_nxt      = clamp_accum(sum_y, accum_limit_r);
          pending_nxt      = 1'b1;
        end
        result.status = ST_SAMPLE_TAKEN;
      end
      KIND_READ: begin
        if (in_data.read_length < {5'b0, ReadMinLength}) begin
          result.status = ST_READ_SHORT;
        end else if (!pending_r) begin
          result.status = ST_NO_DATA;
        end else begin
          result.status      = ST_PACKET_GIVEN;
          result.packet_head = last_buttons_r | HeadMarker;
          result.packet_dx   = rx;
          result.packet_dy   = ry;
          total_x_nxt = total_x_r - {{(TotalWidth-8){rx[7]}}, rx};
          total_y_nxt = total_y_r - {{(TotalWidth-8){ry[7]}}, ry};
          pending_nxt = 1'b0;
        end
      end
      KIND_CLEAR: begin
        last_buttons_nxt = ButtonsReset;
        total_x_nxt      = '0;
        total_y_nxt      = '0;
        pending_nxt      = 1'b0;
        result.status    = ST_CLEARED;
      end
      default: begin
        result.status = ST_NO_DATA;
      end
    endcase
    result.data_ready = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_limit_r  <= AccumLimitReset;
      report_limit_r <= ReportLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ACCUM_LIMIT:  accum_limit_r  <= cfg_data;
        CFG_REPORT_LIMIT: report_limit_r <= cfg_data[ReportWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_buttons_r <= ButtonsReset;
      total_x_r      <= '0;
      total_y_r      <= '0;
      pending_r      <= 1'b0;
    end else if (in_accept) begin
      last_buttons_r <= last_buttons_nxt;
      total_x_r      <= total_x_nxt;
      total_y_r      <= total_y_nxt;
      pending_r      <= pending_nxt;
    end
  end

  // The skid stage only fills when the output register is held and a request arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_accept;
      skid_valid_r <= 1'b0;
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= result;
      end
    end else if (in_accept) begin
      skid_r <= result;
    end
  end

endmodule
